[src/psf_pkg.sv]
// ----------------------------------------------------------------------------
// psf_pkg
// shared constants, state encoding and control structs for the viewport fit
// ----------------------------------------------------------------------------
package psf_pkg;

    // viewport registers and scale format
    localparam int VP_W       = 12;
    localparam int FRAC_W     = 16;
    localparam int SCALE_W    = 28;              // max scale 4095*20*2^16/21 < 2^28
    localparam int V20_W      = VP_W + 5;        // viewport times 20
    localparam int NUM_W      = V20_W + FRAC_W;  // dividend of the scale division
    localparam int CFG_IDX_W  = 1;

    localparam logic [VP_W-1:0] VP_WIDTH_RST  = 12'd640;
    localparam logic [VP_W-1:0] VP_HEIGHT_RST = 12'd480;

    // default parameter values
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VP_WIDTH  = 1'b0,
        CFG_VP_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_SPAN,
        ST_OFFS,
        ST_RD,
        ST_MUL,
        ST_FIT
    } t_state;

    typedef struct packed {
        logic load;       // accept a point into the set
        logic div_start;  // start a scale division
        logic div_y;      // division works on the y axis
        logic cap_sx;     // keep the x scale
        logic cap_s;      // keep the smaller of both scales
        logic span;       // multiply scale by box extent
        logic offs;       // form centering offsets
        logic rd;         // read stored point
        logic mul;        // scale stored point
        logic fit;        // load output register
        logic clear;      // clear the set after the final result
        logic idx_inc;    // next stored point
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic idx_last;
        logic slot_free;
    } t_dp_sts;

endpackage

[src/psf_in_if.sv]
// ----------------------------------------------------------------------------
// psf_in_if
// point input channel: valid/ready with x, y and last mark
// ----------------------------------------------------------------------------
interface psf_in_if #(
    parameter int COORD_BITS = psf_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

[src/psf_out_if.sv]
// ----------------------------------------------------------------------------
// psf_out_if
// fitted point output channel: valid/ready with x, y and last mark
// ----------------------------------------------------------------------------
interface psf_out_if;
    logic                      valid;
    logic                      ready;
    logic [psf_pkg::VP_W-1:0]  fitted_x;
    logic [psf_pkg::VP_W-1:0]  fitted_y;
    logic                      last_fitted;

    modport source (output valid, output fitted_x, output fitted_y, output last_fitted,
                    input ready);
    modport sink   (input valid, input fitted_x, input fitted_y, input last_fitted,
                    output ready);
endinterface

[src/psf_div.sv]
// ----------------------------------------------------------------------------
// psf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psf_div #(
    parameter int NUM_W = psf_pkg::NUM_W,
    parameter int DEN_W = psf_pkg::COORD_BITS_DEF + 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend register doubles as quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

[src/psf_dp.sv]
// ----------------------------------------------------------------------------
// psf_dp
// datapath: point store, bounding box, scale, offsets and output register
// ----------------------------------------------------------------------------
module psf_dp #(
    parameter int MAX_POINTS = psf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psf_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psf_pkg::t_dp_cmd               i_cmd,
    output psf_pkg::t_dp_sts               o_sts,
    input  logic signed [COORD_BITS-1:0]   i_point_x,
    input  logic signed [COORD_BITS-1:0]   i_point_y,
    input  logic                           i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psf_pkg::VP_W-1:0]       i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [psf_pkg::VP_W-1:0]       o_fitted_x,
    output logic [psf_pkg::VP_W-1:0]       o_fitted_y,
    output logic                           o_last_fitted
);
    localparam int CB      = COORD_BITS;
    localparam int VP_W    = psf_pkg::VP_W;
    localparam int SCALE_W = psf_pkg::SCALE_W;
    localparam int FRAC_W  = psf_pkg::FRAC_W;
    localparam int NUM_W   = psf_pkg::NUM_W;
    localparam int V20_W   = psf_pkg::V20_W;
    localparam int DEN_W   = CB + 6;
    localparam int PROD_W  = CB + SCALE_W;
    localparam int FIT_W   = PROD_W - FRAC_W + 1;
    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);

    localparam logic signed [CB-1:0] COORD_MAXV = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] COORD_MINV = {1'b1, {(CB-1){1'b0}}};

    // configuration
    logic [VP_W-1:0] r_vp_w;
    logic [VP_W-1:0] r_vp_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_w <= psf_pkg::VP_WIDTH_RST;
            r_vp_h <= psf_pkg::VP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (psf_pkg::t_cfg_idx'(i_cfg_idx))
                psf_pkg::CFG_VP_WIDTH:  r_vp_w <= i_cfg_data;
                psf_pkg::CFG_VP_HEIGHT: r_vp_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // point store and running box
    logic [2*CB-1:0]      mem [MAX_POINTS];
    logic [2*CB-1:0]      r_rd;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_idx;
    logic signed [CB-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                 room;

    assign room = (r_count < CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            mem[r_count[IDX_W-1:0]] <= {i_point_x, i_point_y};
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_min_x <= COORD_MAXV;
            r_min_y <= COORD_MAXV;
            r_max_x <= COORD_MINV;
            r_max_y <= COORD_MINV;
        end else if (i_cmd.load && room) begin
            r_count <= r_count + 1'b1;
            if (i_point_x < r_min_x) r_min_x <= i_point_x;
            if (i_point_x > r_max_x) r_max_x <= i_point_x;
            if (i_point_y < r_min_y) r_min_y <= i_point_y;
            if (i_point_y > r_max_y) r_max_y <= i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // box extent, max - min, never negative once a point is stored
    logic [CB:0]   diff_x_f, diff_y_f;
    logic [CB-1:0] diff_x, diff_y;
    logic [CB:0]   size_sel;
    logic [VP_W-1:0] vp_sel;

    always_comb begin
        diff_x_f = {r_max_x[CB-1], r_max_x} - {r_min_x[CB-1], r_min_x};
        diff_y_f = {r_max_y[CB-1], r_max_y} - {r_min_y[CB-1], r_min_y};
        diff_x   = diff_x_f[CB-1:0];
        diff_y   = diff_y_f[CB-1:0];
        size_sel = i_cmd.div_y ? ({1'b0, diff_y} + 1'b1) : ({1'b0, diff_x} + 1'b1);
        vp_sel   = i_cmd.div_y ? r_vp_h : r_vp_w;
    end

    // scale = vp * 20 * 2^16 / (size * 21)
    logic [V20_W-1:0] vp_e, v20;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] sz_e, div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    always_comb begin
        vp_e    = V20_W'(vp_sel);
        v20     = (vp_e << 4) + (vp_e << 2);
        div_num = {v20, {FRAC_W{1'b0}}};
        sz_e    = DEN_W'(size_sel);
        div_den = (sz_e << 4) + (sz_e << 2) + sz_e;
    end

    psf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic [SCALE_W-1:0] r_sx, r_s;
    logic [SCALE_W-1:0] quot_s;

    assign quot_s = div_quot[SCALE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_sx) r_sx <= quot_s;
        if (i_cmd.cap_s)  r_s  <= (r_sx < quot_s) ? r_sx : quot_s;
    end

    // one multiplier per axis, shared by span and per-point scaling
    logic [PROD_W-1:0] r_px, r_py;
    logic [CB-1:0]     mul_ax, mul_ay;
    logic [CB:0]       dx_f, dy_f;

    always_comb begin
        dx_f = {r_rd[2*CB-1], r_rd[2*CB-1:CB]} - {r_min_x[CB-1], r_min_x};
        dy_f = {r_rd[CB-1], r_rd[CB-1:0]} - {r_min_y[CB-1], r_min_y};
        mul_ax = i_cmd.span ? diff_x : dx_f[CB-1:0];
        mul_ay = i_cmd.span ? diff_y : dy_f[CB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.span || i_cmd.mul) begin
            r_px <= PROD_W'(mul_ax) * PROD_W'(r_s);
            r_py <= PROD_W'(mul_ay) * PROD_W'(r_s);
        end
    end

    // span = s * size >> 16 = (s * extent + s) >> 16, clipped to viewport
    logic [PROD_W:0]   span_sx, span_sy;
    logic [FIT_W-1:0]  span_x, span_y;
    logic [VP_W-1:0]   span_cx, span_cy;
    logic [VP_W-1:0]   r_offx, r_offy;

    always_comb begin
        span_sx = {1'b0, r_px} + (PROD_W+1)'(r_s);
        span_sy = {1'b0, r_py} + (PROD_W+1)'(r_s);
        span_x  = span_sx[PROD_W:FRAC_W];
        span_y  = span_sy[PROD_W:FRAC_W];
        span_cx = (span_x > FIT_W'(r_vp_w)) ? r_vp_w : span_x[VP_W-1:0];
        span_cy = (span_y > FIT_W'(r_vp_h)) ? r_vp_h : span_y[VP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.offs) begin
            r_offx <= (r_vp_w - span_cx) >> 1;
            r_offy <= (r_vp_h - span_cy) >> 1;
        end
    end

    // fitted coordinate, saturated to viewport
    logic [FIT_W-1:0] fit_x, fit_y;
    logic [VP_W-1:0]  sat_x, sat_y;
    logic             idx_last;

    always_comb begin
        fit_x    = {1'b0, r_px[PROD_W-1:FRAC_W]} + FIT_W'(r_offx);
        fit_y    = {1'b0, r_py[PROD_W-1:FRAC_W]} + FIT_W'(r_offy);
        sat_x    = (fit_x > FIT_W'(r_vp_w)) ? r_vp_w : fit_x[VP_W-1:0];
        sat_y    = (fit_y > FIT_W'(r_vp_h)) ? r_vp_h : fit_y[VP_W-1:0];
        idx_last = (CNT_W'(r_idx) == (r_count - 1'b1));
    end

    logic r_out_valid;
    logic [VP_W-1:0] r_fx, r_fy;
    logic r_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fit) begin
            r_fx <= sat_x;
            r_fy <= sat_y;
            r_fl <= idx_last;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.idx_last  = idx_last;
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_fitted_x    = r_fx;
    assign o_fitted_y    = r_fy;
    assign o_last_fitted = r_fl;
endmodule

[src/psf_ctrl.sv]
// ----------------------------------------------------------------------------
// psf_ctrl
// controller: load, two scale divisions, offsets, then one result per point
// ----------------------------------------------------------------------------
module psf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  psf_pkg::t_dp_sts  i_sts,
    output psf_pkg::t_dp_cmd  o_cmd
);
    psf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psf_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psf_pkg::ST_LOAD: begin
                if (i_in_valid && i_in_last) n_state = psf_pkg::ST_DX_GO;
            end
            psf_pkg::ST_DX_GO:   n_state = psf_pkg::ST_DX_WAIT;
            psf_pkg::ST_DX_WAIT: begin
                if (i_sts.div_done) n_state = psf_pkg::ST_DY_GO;
            end
            psf_pkg::ST_DY_GO:   n_state = psf_pkg::ST_DY_WAIT;
            psf_pkg::ST_DY_WAIT: begin
                if (i_sts.div_done) n_state = psf_pkg::ST_SPAN;
            end
            psf_pkg::ST_SPAN:    n_state = psf_pkg::ST_OFFS;
            psf_pkg::ST_OFFS:    n_state = psf_pkg::ST_RD;
            psf_pkg::ST_RD:      n_state = psf_pkg::ST_MUL;
            psf_pkg::ST_MUL:     n_state = psf_pkg::ST_FIT;
            psf_pkg::ST_FIT: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.idx_last ? psf_pkg::ST_LOAD : psf_pkg::ST_RD;
                end
            end
            default: n_state = psf_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            psf_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            psf_pkg::ST_DX_GO:   o_cmd.div_start = 1'b1;
            psf_pkg::ST_DX_WAIT: o_cmd.cap_sx = i_sts.div_done;
            psf_pkg::ST_DY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_y     = 1'b1;
            end
            psf_pkg::ST_DY_WAIT: o_cmd.cap_s = i_sts.div_done;
            psf_pkg::ST_SPAN:    o_cmd.span = 1'b1;
            psf_pkg::ST_OFFS:    o_cmd.offs = 1'b1;
            psf_pkg::ST_RD:      o_cmd.rd = 1'b1;
            psf_pkg::ST_MUL:     o_cmd.mul = 1'b1;
            psf_pkg::ST_FIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.fit     = 1'b1;
                    o_cmd.clear   = i_sts.idx_last;
                    o_cmd.idx_inc = !i_sts.idx_last;
                end
            end
            default: ;
        endcase
    end
endmodule

[src/point_set_fit_to_viewport.sv]
// ----------------------------------------------------------------------------
// point_set_fit_to_viewport
// fits a loaded point set into the viewport by its bounding box
// ----------------------------------------------------------------------------
//  channel  dir  handshake    transaction payload
//  i_in     in   valid/ready  point_x, point_y, last_point
//  o_out    out  valid/ready  fitted_x, fitted_y, last_fitted
//  cfg      in   i_cfg_we     i_cfg_idx, i_cfg_data (viewport width, height)
//
//  loading accepts one point per cycle; a last point starts the fit
//  the fit runs two serial scale divisions through one restoring divider,
//  then the span and offset steps
//  each stored point then passes store read, multiply and output load
//  a stalled output holds the emit sequence; synchronous active-low reset
// ----------------------------------------------------------------------------
module point_set_fit_to_viewport #(
    parameter int MAX_POINTS = psf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psf_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psf_in_if.sink                        i_in,
    psf_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [psf_pkg::VP_W-1:0]      i_cfg_data
);
    psf_pkg::t_dp_cmd cmd;
    psf_pkg::t_dp_sts sts;

    psf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_point),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    psf_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_point_x     (i_in.point_x),
        .i_point_y     (i_in.point_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_fitted_x    (o_out.fitted_x),
        .o_fitted_y    (o_out.fitted_y),
        .o_last_fitted (o_out.last_fitted)
    );
endmodule

[bench/psf_fit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_fit_checker
// watches the point and fitted point channels and the register port, keeps
// its own copy of the point set and viewport, works out the fitted points of
// every finished set and compares each output transaction field by field
// ----------------------------------------------------------------------------
module psf_fit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psf_in_if                             in_ch,
    psf_out_if                            out_ch,
    input  logic                          i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [psf_pkg::VP_W-1:0]      i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    localparam int NPTS       = psf_pkg::MAX_POINTS_DEF;
    localparam int CW         = psf_pkg::COORD_BITS_DEF;
    localparam int VP_W       = psf_pkg::VP_W;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [VP_W-1:0] x;
        logic [VP_W-1:0] y;
        logic            last;
    } t_fitted_pt;

    t_coord          held_x [NPTS];
    t_coord          held_y [NPTS];
    int              held_cnt;
    t_coord          lo_x, hi_x, lo_y, hi_y;
    logic [VP_W-1:0] vp_w, vp_h;
    t_fitted_pt      fitted_q [$];
    int              result_no;

    task automatic flag(input string msg);
        o_errors++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic drop_set();
        held_cnt = 0;
        lo_x = {1'b0, {(CW-1){1'b1}}};
        lo_y = {1'b0, {(CW-1){1'b1}}};
        hi_x = {1'b1, {(CW-1){1'b0}}};
        hi_y = {1'b1, {(CW-1){1'b0}}};
    endtask

    // Q16.16 scale that fits size into vp with a 1/1.05 margin
    function automatic longint unsigned axis_scale_of(input longint unsigned vp,
                                                      input longint unsigned size);
        return (vp * 20 * 65536) / (size * 21);
    endfunction

    function automatic longint unsigned centre_offset(input longint unsigned vp,
                                                      input longint unsigned sc,
                                                      input longint unsigned size);
        longint unsigned span;
        span = (sc * size) >> 16;
        if (span > vp) begin
            span = vp;
        end
        return (vp - span) >> 1;
    endfunction

    function automatic logic [VP_W-1:0] place(input t_coord p, input t_coord lo,
                                              input longint unsigned sc,
                                              input longint unsigned off,
                                              input longint unsigned vp);
        longint unsigned d, v;
        d = longint'(p) - longint'(lo);
        v = ((d * sc) >> 16) + off;
        if (v > vp) begin
            v = vp;
        end
        return v[VP_W-1:0];
    endfunction

    task automatic fit_point_set();
        longint unsigned box_w, box_h, sx, sy, sc, off_x, off_y;
        t_fitted_pt      pt;
        box_w = longint'(hi_x) - longint'(lo_x) + 1;
        box_h = longint'(hi_y) - longint'(lo_y) + 1;
        sx    = axis_scale_of(vp_w, box_w);
        sy    = axis_scale_of(vp_h, box_h);
        sc    = (sx < sy) ? sx : sy;
        off_x = centre_offset(vp_w, sc, box_w);
        off_y = centre_offset(vp_h, sc, box_h);
        for (int i = 0; i < held_cnt; i++) begin
            pt.x    = place(held_x[i], lo_x, sc, off_x, vp_w);
            pt.y    = place(held_y[i], lo_y, sc, off_y, vp_h);
            pt.last = (i == held_cnt - 1);
            fitted_q.insert(fitted_q.size(), pt);
        end
        drop_set();
    endtask

    task automatic take_point(input t_coord x, input t_coord y, input logic last);
        // a full store drops the point, but its last mark still closes the set
        if (held_cnt < NPTS) begin
            held_x[held_cnt] = x;
            held_y[held_cnt] = y;
            held_cnt++;
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
        end
        if (last && held_cnt != 0) begin
            fit_point_set();
        end
    endtask

    task automatic check_result();
        t_fitted_pt want;
        if (fitted_q.size() == 0) begin
            flag($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
            want = fitted_q.pop_front();
            if (out_ch.fitted_x !== want.x) begin
                flag($sformatf("result %0d fitted_x %0d, expected %0d",
                               result_no, out_ch.fitted_x, want.x));
            end
            if (out_ch.fitted_y !== want.y) begin
                flag($sformatf("result %0d fitted_y %0d, expected %0d",
                               result_no, out_ch.fitted_y, want.y));
            end
            if (out_ch.last_fitted !== want.last) begin
                flag($sformatf("result %0d last_fitted %b, expected %b",
                               result_no, out_ch.last_fitted, want.last));
            end
        end
        result_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drop_set();
            vp_w      = psf_pkg::VP_WIDTH_RST;
            vp_h      = psf_pkg::VP_HEIGHT_RST;
            result_no = 0;
            fitted_q.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_idx == psf_pkg::CFG_VP_WIDTH) begin
                    vp_w = i_cfg_data;
                end else if (i_cfg_idx == psf_pkg::CFG_VP_HEIGHT) begin
                    vp_h = i_cfg_data;
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                take_point(in_ch.point_x, in_ch.point_y, in_ch.last_point);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                check_result();
            end
        end
        o_pending <= fitted_q.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives point sets into the viewport fit with bursty input and a stalling
// output, rewrites the viewport between phases and reports the verdict
// ----------------------------------------------------------------------------
module tb_top;
    localparam int ITEM_TARGET   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int VP_W          = psf_pkg::VP_W;

    typedef logic signed [psf_pkg::COORD_BITS_DEF-1:0] t_coord;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_STRIDE
    } t_rx_pattern;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    psf_pkg::t_cfg_idx cfg_idx;
    logic [VP_W-1:0]   cfg_data;
    logic              hold_go;
    int                hold_left;
    t_rx_pattern       rx_mode;
    int                rx_left;
    int                burst_left = 0;
    int                items_sent = 0;
    int                cycle_cnt  = 0;
    int                err_count;
    int                pending;

    psf_in_if #(.COORD_BITS(psf_pkg::COORD_BITS_DEF)) pt_ch ();
    psf_out_if                                        fit_ch ();

    point_set_fit_to_viewport #(
        .MAX_POINTS (psf_pkg::MAX_POINTS_DEF),
        .COORD_BITS (psf_pkg::COORD_BITS_DEF)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (pt_ch),
        .o_out      (fit_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    psf_fit_checker chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .in_ch      (pt_ch),
        .out_ch     (fit_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (err_count),
        .o_pending  (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: changing stall patterns, plus a long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            fit_ch.ready <= 1'b0;
            hold_left    <= 0;
            rx_mode      <= RX_OPEN;
            rx_left      <= 0;
        end else if (hold_go) begin
            hold_left    <= HOLD_CYCLES;
            fit_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            fit_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_pattern'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   fit_ch.ready <= 1'b1;
                RX_COIN:   fit_ch.ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: fit_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   fit_ch.ready <= (rx_left % 3 == 0);
            endcase
        end
    end

    task automatic send_point(input int x, input int y, input logic last);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(10, 30);
            end else begin
                gap = $urandom_range(1, 4);
            end
            if (gap != 0) begin
                pt_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pt_ch.valid      <= 1'b1;
        pt_ch.point_x    <= t_coord'(x);
        pt_ch.point_y    <= t_coord'(y);
        pt_ch.last_point <= last;
        do @(posedge clk); while (pt_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // stop offering and wait until every fitted point is back
    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_viewport(input int w, input int h);
        cfg_we   <= 1'b1;
        cfg_idx  <= psf_pkg::CFG_VP_WIDTH;
        cfg_data <= VP_W'(w);
        @(posedge clk);
        cfg_idx  <= psf_pkg::CFG_VP_HEIGHT;
        cfg_data <= VP_W'(h);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic int pick_spread();
        case ($urandom_range(0, 9))
            0, 1:    return 0;
            2, 3:    return 3;
            4, 5, 6: return 200;
            default: return -1;
        endcase
    endfunction

    function automatic t_coord pick_coord(input t_coord base, input int spread);
        if (spread < 0) begin
            return t_coord'($urandom);
        end
        return base + t_coord'($urandom_range(0, spread));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return $urandom_range(1, 10);
        if (r < 18) return $urandom_range(11, 40);
        return $urandom_range(41, 70);
    endfunction

    task automatic send_set(input int len);
        t_coord base_x, base_y;
        int     spread_x, spread_y;
        base_x   = t_coord'($urandom);
        base_y   = t_coord'($urandom);
        spread_x = pick_spread();
        spread_y = pick_spread();
        for (int i = 0; i < len; i++) begin
            send_point(int'(pick_coord(base_x, spread_x)),
                       int'(pick_coord(base_y, spread_y)), i == len - 1);
        end
    endtask

    initial begin
        int phase_no;
        int n_sets;
        int len;
        int w, h;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= psf_pkg::CFG_VP_WIDTH;
        cfg_data         <= '0;
        hold_go          <= 1'b0;
        pt_ch.valid      <= 1'b0;
        pt_ch.point_x    <= '0;
        pt_ch.point_y    <= '0;
        pt_ch.last_point <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // viewport left at its reset size
        send_point(0, 0, 1'b1);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b1);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(0, 0, 1'b1);
        // box one point wide in x, then one point high in y
        send_point(100, -5, 1'b0);
        send_point(100, 7, 1'b0);
        send_point(100, 300, 1'b1);
        send_point(-7, -1, 1'b0);
        send_point(9, -1, 1'b1);
        drain();

        set_viewport(4095, 4095);
        send_point(0, 0, 1'b0);
        send_point(1, 1, 1'b1);
        send_point(-32768, 5, 1'b0);
        send_point(32767, -5, 1'b1);
        drain();

        // zero viewport collapses everything to the origin
        set_viewport(0, 0);
        send_point(3, 4, 1'b0);
        send_point(-5, 6, 1'b1);
        drain();

        phase_no = 0;
        while (items_sent < ITEM_TARGET || phase_no < 4) begin
            case (phase_no)
                0: set_viewport(4095, 1);
                1: set_viewport(1, 4095);
                2: set_viewport(4095, 4095);
                3: set_viewport(1, 1);
                default: begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                    : $urandom_range(1, 4095);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                    : $urandom_range(1, 4095);
                    set_viewport(w, h);
                end
            endcase
            n_sets = $urandom_range(2, 5);
            for (int s = 0; s < n_sets; s++) begin
                len = pick_len();
                if (s == 0 && phase_no == 1) begin
                    len = psf_pkg::MAX_POINTS_DEF;          // store exactly full
                end else if (s == 0 && phase_no == 3) begin
                    len = psf_pkg::MAX_POINTS_DEF + 3;      // trailing points dropped
                end else if (s == 0 && phase_no == 2) begin
                    // long output hold while points keep coming
                    hold_go <= 1'b1;
                    @(posedge clk);
                    hold_go <= 1'b0;
                    len = 48;
                end
                send_set(len);
                // next set follows at once behind the held output; other sets drain at random
                if (!(s == 0 && phase_no == 2) && $urandom_range(0, 7) == 0) begin
                    drain();
                end
            end
            drain();
            phase_no++;
        end

        if (err_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
